FILE: design/sim_pkg.sv
package sim_pkg;

  // Width of every interval bound and of a configuration word.
  localparam int unsigned DataW = 32;

  // Default depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEW_START = 1'b0,
    CFG_NEW_END   = 1'b1
  } cfg_idx_e;

  // One classified list item, as queued for the back.
  typedef struct packed {
    logic                    new_first;  // insert the new interval before the item
    logic                    new_after;  // insert the new interval at the end of the list
    logic                    has;        // the item carries an interval
    logic signed [DataW-1:0] s;
    logic signed [DataW-1:0] e;
    logic                    last;       // flush the pending interval afterwards
  } sim_op_t;

endpackage

FILE: design/sim_if.sv
// Input channel: one list item per transfer.
interface sim_in_if;
  import sim_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    has_interval;
  logic signed [DataW-1:0] item_start;
  logic signed [DataW-1:0] item_end;
  logic                    is_last;

  modport source (output valid, has_interval, item_start, item_end, is_last, input ready);
  modport sink   (input valid, has_interval, item_start, item_end, is_last, output ready);
endinterface

// Output channel: one finished merged interval per transfer.
interface sim_out_if;
  import sim_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] out_start;
  logic signed [DataW-1:0] out_end;
  logic                    out_last;

  modport source (output valid, out_start, out_end, out_last, input ready);
  modport sink   (input valid, out_start, out_end, out_last, output ready);
endinterface

FILE: design/sim_front.sv
module sim_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sim_in_if.sink                           in_i,
  input  logic signed [sim_pkg::DataW-1:0] new_start_i,
  output logic                             push_valid_o,
  output sim_pkg::sim_op_t                 push_op_o,
  input  logic                             push_ready_i
);
  import sim_pkg::*;

  logic placed_q, placed_d;
  logic accept;
  logic before_item;

  // The queue's space decides whether an item is taken.
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid & push_ready_i;

  // The new interval goes ahead of the first list interval whose start is not below it,
  // and at the end of the list if no such interval came.
  assign before_item = ~placed_q & in_i.has_interval & (new_start_i <= in_i.item_start);

  always_comb begin
    push_op_o.new_first = before_item;
    push_op_o.new_after = ~placed_q & ~before_item & in_i.is_last;
    push_op_o.has       = in_i.has_interval;
    push_op_o.s         = in_i.item_start;
    push_op_o.e         = in_i.item_end;
    push_op_o.last      = in_i.is_last;
  end

  // Placement flag: set once the new interval is queued, cleared at the end of a list.
  always_comb begin
    placed_d = placed_q;
    if (accept) begin
      if (in_i.is_last) begin
        placed_d = 1'b0;
      end else if (before_item) begin
        placed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q <= 1'b0;
    end else begin
      placed_q <= placed_d;
    end
  end

`ifndef SYNTHESIS
  // A list never sees the new interval inserted twice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && placed_q) |-> !(push_op_o.new_first || push_op_o.new_after))
    else $error("new interval inserted twice in one list");
`endif

endmodule

FILE: design/sim_fifo.sv
module sim_fifo #(
  parameter int unsigned Depth = sim_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  sim_pkg::sim_op_t wr_op_i,
  output logic             wr_ready_o,
  output logic             rd_valid_o,
  output sim_pkg::sim_op_t rd_op_o,
  input  logic             rd_ready_i
);
  import sim_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  sim_op_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_op_o    = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_ready_i & rd_valid_o;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

`ifndef SYNTHESIS
  // The fill count stays within the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue fill count above depth");

  // With the queue empty and nothing pushed, it is still empty in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && !push) |=> !rd_valid_o)
    else $error("queue produced an entry from nothing");
`endif

endmodule

FILE: design/sim_back.sv
module sim_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             op_valid_i,
  input  sim_pkg::sim_op_t                 op_i,
  output logic                             op_ready_o,
  input  logic signed [sim_pkg::DataW-1:0] new_start_i,
  input  logic signed [sim_pkg::DataW-1:0] new_end_i,
  sim_out_if.source                        out_o
);
  import sim_pkg::*;

  // Pending merged interval.
  logic signed [DataW-1:0] pend_start_q, pend_start_d;
  logic signed [DataW-1:0] pend_end_q, pend_end_d;
  logic                    pend_valid_q, pend_valid_d;

  // Steps of the head entry already carried out: before, item, after.
  logic [2:0] done_q, done_d;
  logic [2:0] done_set;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] out_start_q, out_end_q;
  logic                    out_last_q;

  logic signed [DataW-1:0] sel_s, sel_e;
  logic                    is_absorb, is_flush, is_final;
  logic                    emit, out_free, go;
  logic                    pre_pend, item_pend, post_pend;

  assign pre_pend  = op_i.new_first & ~done_q[0];
  assign item_pend = op_i.has & ~done_q[1];
  assign post_pend = op_i.new_after & ~done_q[2];

  // Pick the head entry's next step, one per cycle unless output stalls.
  always_comb begin
    sel_s     = new_start_i;
    sel_e     = new_end_i;
    is_absorb = 1'b0;
    is_flush  = 1'b0;
    is_final  = 1'b1;
    done_set  = 3'b000;
    if (pre_pend) begin
      is_absorb = 1'b1;
      is_final  = ~(item_pend | post_pend | op_i.last);
      done_set  = 3'b001;
    end else if (item_pend) begin
      sel_s     = op_i.s;
      sel_e     = op_i.e;
      is_absorb = 1'b1;
      is_final  = ~(post_pend | op_i.last);
      done_set  = 3'b010;
    end else if (post_pend) begin
      is_absorb = 1'b1;
      is_final  = ~op_i.last;
      done_set  = 3'b100;
    end else if (op_i.last) begin
      is_flush = 1'b1;
    end
  end

  // A step that finishes an interval waits for room in the output register.
  assign emit       = is_flush | (is_absorb & pend_valid_q & ~(pend_end_q >= sel_s));
  assign out_free   = ~out_valid_q | out_o.ready;
  assign go         = op_valid_i & (~emit | out_free);
  assign op_ready_o = go & is_final;

  // Merge the selected interval into the pending one, or flush it.
  always_comb begin
    pend_start_d = pend_start_q;
    pend_end_d   = pend_end_q;
    pend_valid_d = pend_valid_q;
    done_d       = done_q;
    if (go) begin
      done_d = is_final ? 3'b000 : (done_q | done_set);
      if (is_flush) begin
        pend_valid_d = 1'b0;
      end else if (is_absorb) begin
        if (!pend_valid_q || emit) begin
          pend_start_d = sel_s;
          pend_end_d   = sel_e;
          pend_valid_d = 1'b1;
        end else if (sel_e > pend_end_q) begin
          pend_end_d = sel_e;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_o.ready;
    if (go && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_start_q <= '0;
      pend_end_q   <= '0;
      pend_valid_q <= 1'b0;
      done_q       <= 3'b000;
      out_valid_q  <= 1'b0;
    end else begin
      pend_start_q <= pend_start_d;
      pend_end_q   <= pend_end_d;
      pend_valid_q <= pend_valid_d;
      done_q       <= done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload is loaded with the finished interval.
  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_start_q <= pend_start_q;
      out_end_q   <= pend_end_q;
      out_last_q  <= is_flush;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_start = out_start_q;
  assign out_o.out_end   = out_end_q;
  assign out_o.out_last  = out_last_q;

`ifndef SYNTHESIS
  // After a flush no interval is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && is_flush) |=> !pend_valid_q)
    else $error("pending interval survived a flush");

  // Finishing the head entry leaves no step marks behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_ready_o |=> (done_q == 3'b000))
    else $error("step marks not cleared after the entry retired");
`endif

endmodule

FILE: design/sorted_interval_insert_merge.sv
// Inserts the interval held in the two configuration registers into a stream of closed
// intervals sorted by start, and merges every overlapping or touching pair on the way.
// The front takes one list item per cycle while the queue has room and decides where
// the new interval falls; a short queue (QueueDepth entries) separates it from the
// back, which carries out one merge step per cycle against the single pending interval
// unless a finishing step meets a busy output register. An item makes a back step,
// plus one where the new interval is inserted and one for a list's closing flush; an
// empty item that does not end the list yields nothing. Finished intervals leave
// through an output register, so the back keeps working while a result waits unless it
// has another to deliver. Write the registers only while no list is in flight.
module sorted_interval_insert_merge #(
  parameter int unsigned QueueDepth = sim_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sim_in_if.sink                            in_i,
  sim_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [sim_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sim_pkg::DataW-1:0]         cfg_data_i
);
  import sim_pkg::*;

  logic signed [DataW-1:0] new_start_q, new_end_q;

  logic    push_valid, push_ready;
  sim_op_t push_op;
  logic    pop_valid, pop_ready;
  sim_op_t pop_op;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_start_q <= '0;
      new_end_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NEW_START: new_start_q <= cfg_data_i;
        CFG_NEW_END:   new_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sim_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .new_start_i  (new_start_q),
    .push_valid_o (push_valid),
    .push_op_o    (push_op),
    .push_ready_i (push_ready)
  );

  sim_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_op_i    (push_op),
    .wr_ready_o (push_ready),
    .rd_valid_o (pop_valid),
    .rd_op_o    (pop_op),
    .rd_ready_i (pop_ready)
  );

  sim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (pop_valid),
    .op_i        (pop_op),
    .op_ready_o  (pop_ready),
    .new_start_i (new_start_q),
    .new_end_i   (new_end_q),
    .out_o       (out_o)
  );

endmodule

FILE: tb/sorted_interval_insert_merge_tb.sv
module sorted_interval_insert_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sim_pkg::*;

  localparam int unsigned ResetCycles = 10;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned LongHold    = 100;
  localparam int unsigned WatchLimit  = 2000;
  localparam int unsigned TargetItems = 320;

  localparam logic signed [DataW-1:0] IntMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] IntMax = {1'b0, {(DataW-1){1'b1}}};

  // One list item as offered on the input channel.
  typedef struct packed {
    logic                    has;
    logic signed [DataW-1:0] s;
    logic signed [DataW-1:0] e;
    logic                    last;
  } list_item_t;

  // One finished merged interval as seen on the output channel.
  typedef struct packed {
    logic signed [DataW-1:0] lo;
    logic signed [DataW-1:0] hi;
    logic                    last;
  } merged_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [DataW-1:0]    cfg_data_i;

  sim_in_if  in_if ();
  sim_out_if out_if ();

  sorted_interval_insert_merge dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Items waiting for the driver, and intervals the block still owes us.
  list_item_t  item_q[$];
  merged_t     pending_merged[$];
  int unsigned items_unaccepted = 0;
  int unsigned stim_count       = 0;
  int unsigned err_cnt          = 0;
  int unsigned hold_req         = 0;

  // Our own copy of the registers and of the merge state.
  logic signed [DataW-1:0] ins_start;
  logic signed [DataW-1:0] ins_end;
  logic signed [DataW-1:0] run_lo;
  logic signed [DataW-1:0] run_hi;
  bit                      run_open;
  bit                      ins_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Folds one interval into the running merged interval, closing it when it cannot join.
  task automatic fold_interval(input logic signed [DataW-1:0] s,
                               input logic signed [DataW-1:0] e);
    if (!run_open) begin
      run_lo   = s;
      run_hi   = e;
      run_open = 1'b1;
    end else if (run_hi >= s) begin
      if (e > run_hi) run_hi = e;
    end else begin
      pending_merged.insert(pending_merged.size(),
                            merged_t'{lo: run_lo, hi: run_hi, last: 1'b0});
      run_lo = s;
      run_hi = e;
    end
  endtask

  // Advances the merge by one accepted item and queues the intervals it finishes.
  task automatic advance_merge(input list_item_t it);
    if (it.has) begin
      if (!ins_done && ins_start <= it.s) begin
        fold_interval(ins_start, ins_end);
        ins_done = 1'b1;
      end
      fold_interval(it.s, it.e);
    end
    if (it.last) begin
      if (!ins_done) fold_interval(ins_start, ins_end);
      pending_merged.insert(pending_merged.size(),
                            merged_t'{lo: run_lo, hi: run_hi, last: 1'b1});
      run_open = 1'b0;
      ins_done = 1'b0;
    end
  endtask

  // Wait before the next transfer: none in calm stretches, a random one in busy ones.
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Driver: offers queued items, with a random gap after each transfer.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit          took;
    bit          drv_calm;
    int unsigned gap_left;
    list_item_t  cur_item;
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.has_interval <= 1'b0;
      in_if.item_start   <= '0;
      in_if.item_end     <= '0;
      in_if.is_last      <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_if.valid && in_if.ready;
      if (took) begin
        advance_merge(cur_item);
        items_unaccepted--;
      end
      if (!in_if.valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          cur_item = item_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.has_interval <= cur_item.has;
          in_if.item_start   <= cur_item.s;
          in_if.item_end     <= cur_item.e;
          in_if.is_last      <= cur_item.last;
          gap_left = draw_wait(drv_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every output transfer against the oldest predicted interval.
  always @(posedge clk_i or negedge rst_ni) begin : sink_proc
    bit          sink_calm;
    int unsigned wait_left;
    int unsigned hold_seen;
    merged_t     got;
    merged_t     want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      wait_left = 0;
      hold_seen = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{lo: out_if.out_start, hi: out_if.out_end, last: out_if.out_last};
        if (pending_merged.size() == 0) begin
          $display("%0t: unexpected interval [%0d, %0d] last %0b", $time,
                   got.lo, got.hi, got.last);
          err_cnt++;
        end else begin
          want = pending_merged.pop_front();
          if (got !== want) begin
            $display({"%0t: interval mismatch, expected [%0d, %0d] last %0b,",
                      " got [%0d, %0d] last %0b"},
                     $time, want.lo, want.hi, want.last, got.lo, got.hi, got.last);
            err_cnt++;
          end
        end
        wait_left = draw_wait(sink_calm);
      end
      // A long hold-off, so that the block backs up and stalls its input.
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        wait_left = LongHold;
      end
      if (wait_left > 0) begin
        wait_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin : watch_proc
    int unsigned idle_cyc;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WatchLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d items and %0d intervals outstanding",
                 $time, idle_cyc, items_unaccepted, pending_merged.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic push_item(input bit has, input logic signed [DataW-1:0] s,
                           input logic signed [DataW-1:0] e, input bit last);
    item_q.insert(item_q.size(), list_item_t'{has: has, s: s, e: e, last: last});
    items_unaccepted++;
    stim_count++;
  endtask

  // Writes the interval to insert; only called while the block is idle.
  task automatic load_new_interval(input bit wr_s, input bit wr_e,
                                   input logic signed [DataW-1:0] s,
                                   input logic signed [DataW-1:0] e);
    if (wr_s) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_NEW_START;
      cfg_data_i <= s;
      ins_start = s;
    end
    if (wr_e) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_NEW_END;
      cfg_data_i <= e;
      ins_end = e;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every item is taken and every interval has come out, then lets the block settle.
  task automatic wait_drained();
    while (items_unaccepted != 0 || pending_merged.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Queues a list sorted by start, with optional ignored items and an optional separate terminator.
  task automatic queue_sorted_list(input int unsigned n, input logic signed [DataW-1:0] base,
                                   input int unsigned step_max, input int unsigned len_max,
                                   input int unsigned noise_pct, input bit term);
    logic signed [DataW-1:0] cur;
    logic signed [DataW-1:0] len;
    cur = base;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) push_item(1'b0, $urandom, $urandom, 1'b0);
      cur = cur + $urandom_range(0, step_max);
      len = $urandom_range(0, len_max);
      push_item(1'b1, cur, cur + len, (i == n - 1) && !term);
    end
    if (term || n == 0) push_item(1'b0, $urandom, $urandom, 1'b1);
  endtask

  initial begin : stim
    logic signed [DataW-1:0] base;
    logic signed [DataW-1:0] ns;
    logic signed [DataW-1:0] ne;
    int unsigned             n;
    int unsigned             step;
    int unsigned             kind;
    int unsigned             phase;
    bit                      wr_s;
    bit                      wr_e;

    // Known values on every input from time zero.
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_NEW_START;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.has_interval = 1'b0;
    in_if.item_start   = '0;
    in_if.item_end     = '0;
    in_if.is_last      = 1'b0;
    out_if.ready       = 1'b0;
    ins_start          = '0;
    ins_end            = '0;
    run_lo             = '0;
    run_hi             = '0;
    run_open           = 1'b0;
    ins_done           = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: only the new interval comes out.
    load_new_interval(1'b1, 1'b1, 5, 8);
    push_item(1'b0, IntMax, IntMin, 1'b1);
    wait_drained();

    // Touching neighbors, an ignored item, and a list interval with the same start.
    load_new_interval(1'b1, 1'b1, 10, 15);
    push_item(1'b1, 1, 3, 1'b0);
    push_item(1'b1, 3, 4, 1'b0);
    push_item(1'b0, $urandom, $urandom, 1'b0);
    push_item(1'b1, 10, 12, 1'b0);
    push_item(1'b1, 20, 30, 1'b1);
    wait_drained();

    // Extremes of the signed range.
    load_new_interval(1'b1, 1'b1, IntMin, IntMin);
    push_item(1'b1, IntMin, IntMax, 1'b0);
    push_item(1'b1, IntMax, IntMax, 1'b1);
    wait_drained();

    // New interval after all; start above end and an unsorted list; empty terminator.
    load_new_interval(1'b1, 1'b1, IntMax, IntMax);
    push_item(1'b1, 0, 0, 1'b0);
    push_item(1'b1, 7, 2, 1'b0);
    push_item(1'b1, -5, -9, 1'b0);
    push_item(1'b0, 0, 0, 1'b1);
    wait_drained();

    // New interval with start above end.
    load_new_interval(1'b1, 1'b1, 100, 50);
    push_item(1'b1, 40, 60, 1'b0);
    push_item(1'b1, 100, 100, 1'b0);
    push_item(1'b1, 101, 120, 1'b1);
    wait_drained();

    // Only the end register changes; the new interval follows a single list interval.
    load_new_interval(1'b0, 1'b1, 0, 200);
    push_item(1'b1, -3, -1, 1'b1);
    wait_drained();

    // Random lists, mostly sorted with small steps so that merges are frequent.
    phase = 0;
    while (stim_count < TargetItems) begin
      phase++;
      n    = $urandom_range(1, 6);
      step = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'h0FFF_FFFF)
                                         : $urandom_range(1, 8);
      base = $urandom_range(0, 200);
      base = base - 100;
      if ($urandom_range(0, 2) == 0) base = $urandom;

      // Where the new interval falls, relative to the list.
      case ($urandom_range(0, 9))
        0: begin
          ns = $urandom;
          ne = $urandom;
        end
        8: begin
          ns = $urandom_range(0, 1) ? IntMin : IntMax;
          ne = $urandom_range(0, 1) ? IntMin : IntMax;
        end
        9: begin
          ns = base + $urandom_range(0, 40);
          ne = ns - $urandom_range(1, 10);
        end
        default: begin
          if (step > 1000) ns = base + $urandom;
          else ns = base + $urandom_range(0, (n + 2) * step) - step;
          ne = ns + $urandom_range(0, 2 * step);
        end
      endcase
      wr_s = (phase == 1) || ($urandom_range(0, 3) != 0);
      wr_e = (phase == 1) || ($urandom_range(0, 3) != 0);
      if (wr_s || wr_e) load_new_interval(wr_s, wr_e, ns, ne);

      if (phase == 8) begin
        // Many short intervals, then the receiver holds off while they are offered.
        load_new_interval(1'b1, 1'b1, IntMax, IntMax);
        queue_sorted_list(12, base, 10, 3, 0, 1'b0);
        hold_req++;
      end else begin
        kind = $urandom_range(0, 9);
        case (kind)
          0: push_item(1'b0, $urandom, $urandom, 1'b1);
          1: begin
            for (int unsigned i = 0; i < n; i++) push_item(1'b1, $urandom, $urandom, i == n - 1);
          end
          default: queue_sorted_list(n, base, step, step + 2, (kind == 2) ? 40 : 8,
                                     $urandom_range(0, 3) == 0);
        endcase
      end
      wait_drained();
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/sim_pkg.sv
design/sim_if.sv
design/sim_front.sv
design/sim_fifo.sv
design/sim_back.sv
design/sorted_interval_insert_merge.sv
tb/sorted_interval_insert_merge_tb.sv
